// ===== rtl/core/matrix_text_parser_square_check_assert.svh =====
// Assertion macros for the checker file mtpsq_port_check.sv.
`ifndef MATRIX_TEXT_PARSER_SQUARE_CHECK_ASSERT_SVH
`define MATRIX_TEXT_PARSER_SQUARE_CHECK_ASSERT_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define MTPSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, checked during reset too.
`define MTPSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/mtpsq_pkg.sv =====
`default_nettype none

package mtpsq_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 10;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned AccExtW = 36;

  localparam logic [ByteW-1:0] RowDelimReset = 8'd10;
  localparam logic [ByteW-1:0] ColDelimReset = 8'd32;

  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChTab   = 8'd9;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChPlus  = 8'd43;
  localparam logic [ByteW-1:0] ChMinus = 8'd45;
  localparam logic [ByteW-1:0] ChZero  = 8'd48;
  localparam logic [ByteW-1:0] ChNine  = 8'd57;

  localparam logic [ValueW-1:0] MagLimit = 32'h8000_0000;
  localparam logic [ValueW-1:0] PosMax   = 32'h7FFF_FFFF;

  localparam logic KindElement = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [0:0] {
    CfgRowDelim = 1'b0,
    CfgColDelim = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    PhSkip   = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } num_phase_e;

  typedef struct packed {
    logic                     elem_v;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        row;
    logic [IndexW-1:0]        col;
    logic                     verd_v;
    logic                     square;
    logic [SizeW-1:0]         size;
  } res_bundle_t;

endpackage

`default_nettype wire

// ===== rtl/core/matrix_text_parser_square_check.sv =====
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_ready_o    data_byte_i, end_of_text_i
// out      source     out_valid_o / out_ready_i  result_kind_o .. run_last_o
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while ready; its state update and results are registered
// at the same edge, through one 36-bit multiply-by-ten-add and a few compares.
// A byte gives up to two results (element, then verdict) in one bundle of the
// two-bundle output queue; it drains one result a cycle when out_ready_i is high.
// in_ready_o drops only while the second queue slot is occupied.
// Reset restores the delimiters to newline and space and clears all parse state.
`default_nettype none

module matrix_text_parser_square_check #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [mtpsq_pkg::ByteW-1:0]         data_byte_i,
  input  wire logic                                end_of_text_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     result_kind_o,
  output logic signed [mtpsq_pkg::ValueW-1:0]      element_value_o,
  output logic [mtpsq_pkg::IndexW-1:0]             elem_row_o,
  output logic [mtpsq_pkg::IndexW-1:0]             elem_col_o,
  output logic                                     is_square_o,
  output logic [mtpsq_pkg::SizeW-1:0]              matrix_size_o,
  output logic                                     run_last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [0:0]                          cfg_index_i,
  input  wire logic [mtpsq_pkg::ByteW-1:0]         cfg_data_i
);
  import mtpsq_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM + 2);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_DIM + 1);
  localparam logic [CntW-1:0] CntLim = CntW'(MAX_DIM);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [ByteW-1:0]  row_delim_q, col_delim_q;

  logic              in_row_q, in_row_d;
  logic              in_field_q, in_field_d;
  num_phase_e        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [CntW-1:0]   field_cnt_q, field_cnt_d;
  logic [CntW-1:0]   line_cnt_q, line_cnt_d;
  logic [CntW-1:0]   prev_cnt_q, prev_cnt_d;
  logic              mismatch_q, mismatch_d;

  res_bundle_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic              v0_q, v0_d, v1_q, v1_d;

  logic              in_fire, out_fire, partial, pop, push;
  res_bundle_t       fresh;

  logic              is_row, is_col, is_other, blank, digit;
  num_phase_e        phase_s, phase_f;
  logic              neg_s, neg_f;
  logic [ValueW-1:0] acc_s, acc_f;
  logic [AccExtW-1:0] mul10;
  logic              in_row_1, in_field_1, neg_1;
  logic [ValueW-1:0] acc_1, elem_val;
  logic              emit_elem, close_row, square;
  logic [CntW-1:0]   fc_1, fc_2, line_2, prev_2;
  logic              mismatch_2;
  logic [31:0]       line_ext, field_ext, size_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !v1_q;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_delim_q <= RowDelimReset;
      col_delim_q <= ColDelimReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRowDelim: row_delim_q <= cfg_data_i;
        CfgColDelim: col_delim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_row   = (data_byte_i == row_delim_q);
    is_col   = !is_row && (data_byte_i == col_delim_q);
    is_other = !is_row && !is_col;
    blank    = (data_byte_i == ChSpace) || (data_byte_i >= ChTab && data_byte_i <= ChCr);
    digit    = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);

    // start a fresh field on its first byte
    phase_s = in_field_q ? phase_q : PhSkip;
    neg_s   = in_field_q ? neg_q : 1'b0;
    acc_s   = in_field_q ? acc_q : '0;

    mul10 = {1'b0, acc_s, 3'b000} + {3'b000, acc_s, 1'b0} + AccExtW'(data_byte_i[3:0]);

    phase_f = phase_s;
    neg_f   = neg_s;
    acc_f   = acc_s;
    priority if (phase_s == PhSkip && blank) begin
      phase_f = PhSkip;
    end else if (phase_s == PhSkip && (data_byte_i == ChPlus || data_byte_i == ChMinus)) begin
      neg_f   = (data_byte_i == ChMinus);
      phase_f = PhSign;
    end else if (phase_s != PhDone && digit) begin
      acc_f   = (mul10 > AccExtW'(MagLimit)) ? MagLimit : mul10[ValueW-1:0];
      phase_f = PhDigits;
    end else begin
      phase_f = PhDone;
    end

    in_field_1 = is_other;
    in_row_1   = is_row ? in_row_q : 1'b1;
    neg_1      = is_other ? neg_f : neg_q;
    acc_1      = is_other ? acc_f : acc_q;

    emit_elem = (!is_other && in_field_q) || (end_of_text_i && is_other);
    elem_val  = neg_1 ? (32'd0 - acc_1) : ((acc_1 > PosMax) ? PosMax : acc_1);
    fc_1 = (emit_elem && field_cnt_q < CntMax) ? field_cnt_q + CntOne : field_cnt_q;

    close_row  = in_row_1 && (is_row || end_of_text_i);
    line_2     = (close_row && line_cnt_q < CntMax) ? line_cnt_q + CntOne : line_cnt_q;
    mismatch_2 = mismatch_q || (close_row && line_2 > CntOne && fc_1 != prev_cnt_q);
    prev_2     = close_row ? fc_1 : prev_cnt_q;
    fc_2       = close_row ? '0 : fc_1;

    square = !mismatch_2 && (line_2 != '0) && (line_2 <= CntLim) && (prev_2 == line_2);

    line_ext  = 32'(line_cnt_q);
    field_ext = 32'(field_cnt_q);
    size_ext  = square ? 32'(line_2) : 32'd0;

    fresh.elem_v = emit_elem;
    fresh.value  = $signed(elem_val);
    fresh.row    = line_ext[IndexW-1:0];
    fresh.col    = field_ext[IndexW-1:0];
    fresh.verd_v = end_of_text_i;
    fresh.square = square;
    fresh.size   = size_ext[SizeW-1:0];

    in_row_d    = in_row_q;
    in_field_d  = in_field_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    field_cnt_d = field_cnt_q;
    line_cnt_d  = line_cnt_q;
    prev_cnt_d  = prev_cnt_q;
    mismatch_d  = mismatch_q;
    if (in_fire) begin
      if (end_of_text_i) begin
        in_row_d    = 1'b0;
        in_field_d  = 1'b0;
        phase_d     = PhSkip;
        neg_d       = 1'b0;
        acc_d       = '0;
        field_cnt_d = '0;
        line_cnt_d  = '0;
        prev_cnt_d  = '0;
        mismatch_d  = 1'b0;
      end else begin
        in_row_d    = close_row ? 1'b0 : in_row_1;
        in_field_d  = in_field_1;
        phase_d     = is_other ? phase_f : phase_q;
        neg_d       = neg_1;
        acc_d       = acc_1;
        field_cnt_d = fc_2;
        line_cnt_d  = line_2;
        prev_cnt_d  = prev_2;
        mismatch_d  = mismatch_2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= 1'b0;
      in_field_q  <= 1'b0;
      phase_q     <= PhSkip;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      field_cnt_q <= '0;
      line_cnt_q  <= '0;
      prev_cnt_q  <= '0;
      mismatch_q  <= 1'b0;
    end else begin
      in_row_q    <= in_row_d;
      in_field_q  <= in_field_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      field_cnt_q <= field_cnt_d;
      line_cnt_q  <= line_cnt_d;
      prev_cnt_q  <= prev_cnt_d;
      mismatch_q  <= mismatch_d;
    end
  end

  // output queue: the head shows its element first, then its verdict
  assign out_fire = v0_q && out_ready_i;
  assign partial  = out_fire && slot0_q.elem_v && slot0_q.verd_v;
  assign pop      = out_fire && !partial;
  assign push     = in_fire && (emit_elem || end_of_text_i);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    if (partial) begin
      slot0_d.elem_v = 1'b0;
    end
    if (pop) begin
      slot0_d = slot1_q;
      v0_d    = v1_q;
      v1_d    = 1'b0;
    end
    if (push) begin
      if (!v0_d) begin
        slot0_d = fresh;
        v0_d    = 1'b1;
      end else begin
        slot1_d = fresh;
        v1_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_q <= '0;
      slot1_q <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      slot0_q <= slot0_d;
      slot1_q <= slot1_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
    end
  end

  assign out_valid_o     = v0_q;
  assign result_kind_o   = slot0_q.elem_v ? KindElement : KindVerdict;
  assign element_value_o = slot0_q.elem_v ? slot0_q.value : '0;
  assign elem_row_o      = slot0_q.elem_v ? slot0_q.row : '0;
  assign elem_col_o      = slot0_q.elem_v ? slot0_q.col : '0;
  assign is_square_o     = slot0_q.elem_v ? 1'b0 : slot0_q.square;
  assign matrix_size_o   = slot0_q.elem_v ? '0 : slot0_q.size;
  assign run_last_o      = slot0_q.elem_v ? !slot0_q.verd_v : 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/mtpsq_port_check.sv =====
`default_nettype none

`include "matrix_text_parser_square_check_assert.svh"

module mtpsq_port_check (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic                                result_kind_o,
  input wire logic signed [mtpsq_pkg::ValueW-1:0] element_value_o,
  input wire logic [mtpsq_pkg::IndexW-1:0]        elem_row_o,
  input wire logic [mtpsq_pkg::IndexW-1:0]        elem_col_o,
  input wire logic                                is_square_o,
  input wire logic [mtpsq_pkg::SizeW-1:0]         matrix_size_o,
  input wire logic                                run_last_o
);
  import mtpsq_pkg::*;

  `MTPSQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) && $stable(element_value_o) && $stable(matrix_size_o), "result changed while stalled")
  `MTPSQ_ASSERT(a_verdict_shape, out_valid_o && result_kind_o == KindVerdict |-> run_last_o && element_value_o == 0 && elem_row_o == 0 && elem_col_o == 0 && (is_square_o || matrix_size_o == 0), "malformed verdict")
  `MTPSQ_ASSERT(a_element_shape, out_valid_o && result_kind_o == KindElement |-> !is_square_o && matrix_size_o == 0, "element carries verdict fields")
  `MTPSQ_ASSERT(a_verdict_follows, out_valid_o && out_ready_i && result_kind_o == KindElement && !run_last_o |=> out_valid_o && result_kind_o == KindVerdict, "verdict missing after element")

endmodule

bind matrix_text_parser_square_check mtpsq_port_check u_port_check (.*);

`default_nettype wire

// ===== tb/tb_matrix_text_parser_square_check.sv =====
`timescale 1ns / 1ps

module tb_matrix_text_parser_square_check;
  import mtpsq_pkg::*;

  localparam int MaxDim = 1024;
  localparam logic [SizeW-1:0] CountSat = SizeW'(MaxDim + 1);
  localparam int CycleLimit = 600000;
  localparam int RandomItems = 1300;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic                     kind;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        row;
    logic [IndexW-1:0]        col;
    logic                     square;
    logic [SizeW-1:0]         size;
    logic                     last;
  } parsed_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [ByteW-1:0]         data_byte_i = '0;
  logic                     end_of_text_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     result_kind_o;
  logic signed [ValueW-1:0] element_value_o;
  logic [IndexW-1:0]        elem_row_o;
  logic [IndexW-1:0]        elem_col_o;
  logic                     is_square_o;
  logic [SizeW-1:0]         matrix_size_o;
  logic                     run_last_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [0:0]               cfg_index_i = '0;
  logic [ByteW-1:0]         cfg_data_i = '0;

  matrix_text_parser_square_check #(
    .MAX_DIM(MaxDim)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .element_value_o(element_value_o),
    .elem_row_o     (elem_row_o),
    .elem_col_o     (elem_col_o),
    .is_square_o    (is_square_o),
    .matrix_size_o  (matrix_size_o),
    .run_last_o     (run_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // parser state as the block should hold it
  logic [ByteW-1:0]  row_delim;
  logic [ByteW-1:0]  col_delim;
  logic              p_in_row;
  logic              p_in_field;
  num_phase_e        p_phase;
  logic              p_negative;
  logic [ValueW-1:0] p_magnitude;
  logic [SizeW-1:0]  p_fields;
  logic [SizeW-1:0]  p_rows;
  logic [SizeW-1:0]  p_prev_fields;
  logic              p_ragged;

  parsed_result_t pending_results[$];
  parsed_result_t byte_results[$];
  logic [ByteW-1:0] text_bytes[$];
  string edge_numbers[4] = '{"2147483647", "2147483648", "2147483649", "99999999999"};

  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  rx_hold = 0;
  bit  quiet = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s differs, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    parsed_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, kind", result_kind_o, -1);
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", result_kind_o, want.kind);
        if (element_value_o !== want.value)
          report_mismatch("element_value", longint'(element_value_o), longint'(want.value));
        if (elem_row_o !== want.row)
          report_mismatch("elem_row", elem_row_o, want.row);
        if (elem_col_o !== want.col)
          report_mismatch("elem_col", elem_col_o, want.col);
        if (is_square_o !== want.square)
          report_mismatch("is_square", is_square_o, want.square);
        if (matrix_size_o !== want.size)
          report_mismatch("matrix_size", matrix_size_o, want.size);
        if (run_last_o !== want.last)
          report_mismatch("run_last", run_last_o, want.last);
      end
    end
  end

  function automatic logic [SizeW-1:0] bump_count(input logic [SizeW-1:0] v);
    return (v >= CountSat) ? CountSat : v + 1'b1;
  endfunction

  task automatic restart_parse();
    p_in_row      = 1'b0;
    p_in_field    = 1'b0;
    p_phase       = PhSkip;
    p_negative    = 1'b0;
    p_magnitude   = '0;
    p_fields      = '0;
    p_rows        = '0;
    p_prev_fields = '0;
    p_ragged      = 1'b0;
  endtask

  task automatic close_field();
    parsed_result_t r;
    if (p_in_field) begin
      r       = '0;
      r.kind  = KindElement;
      r.value = p_negative ? ValueW'(0) - p_magnitude
                           : ((p_magnitude > PosMax) ? PosMax : p_magnitude);
      r.row   = p_rows[IndexW-1:0];
      r.col   = p_fields[IndexW-1:0];
      byte_results.push_back(r);
      p_fields   = bump_count(p_fields);
      p_in_field = 1'b0;
    end
  endtask

  task automatic close_row();
    if (p_in_row) begin
      p_rows = bump_count(p_rows);
      if (p_rows > 1 && p_fields != p_prev_fields) p_ragged = 1'b1;
      p_prev_fields = p_fields;
      p_fields      = '0;
      p_in_row      = 1'b0;
    end
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b, input logic eot);
    parsed_result_t r;
    logic           blank;
    logic           digit;
    logic [63:0]    m;
    byte_results.delete();
    blank = (b == ChSpace) || (b >= ChTab && b <= ChCr);
    digit = (b >= ChZero && b <= ChNine);
    if (b == row_delim) begin
      close_field();
      close_row();
    end else begin
      p_in_row = 1'b1;
      if (b == col_delim) begin
        close_field();
      end else begin
        if (!p_in_field) begin
          p_in_field  = 1'b1;
          p_phase     = PhSkip;
          p_negative  = 1'b0;
          p_magnitude = '0;
        end
        if (p_phase == PhSkip && (b == ChPlus || b == ChMinus)) begin
          p_negative = (b == ChMinus);
          p_phase    = PhSign;
        end else if (p_phase != PhDone && digit) begin
          m = 64'(p_magnitude) * 64'd10 + 64'(b - ChZero);
          p_magnitude = (m > 64'(MagLimit)) ? MagLimit : m[ValueW-1:0];
          p_phase     = PhDigits;
        end else if (!(p_phase == PhSkip && blank)) begin
          p_phase = PhDone;
        end
      end
    end
    if (eot) begin
      close_field();
      close_row();
      r        = '0;
      r.kind   = KindVerdict;
      r.square = !p_ragged && p_rows > 0 && p_rows <= MaxDim && p_prev_fields == p_rows;
      r.size   = r.square ? p_rows : '0;
      byte_results.push_back(r);
      restart_parse();
    end
    if (byte_results.size() > 0) byte_results[$].last = 1'b1;
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    parse_byte(b, eot);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_delimiters(input logic [ByteW-1:0] rdel, input logic [ByteW-1:0] cdel);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgRowDelim;
    cfg_data_i  <= rdel;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    row_delim = rdel;
    @(negedge clk_i);
    cfg_index_i <= CfgColDelim;
    cfg_data_i  <= cdel;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    col_delim = cdel;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_str(input string s);
    foreach (s[i]) text_bytes.push_back(s[i]);
  endtask

  task automatic add_run(input logic [ByteW-1:0] d, input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) text_bytes.push_back(d);
  endtask

  task automatic add_number();
    int pick;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        text_bytes.push_back($urandom_range(0, 1) ? ChSpace : ByteW'($urandom_range(9, 13)));
    pick = $urandom_range(0, 3);
    if (pick == 1) text_bytes.push_back(ChPlus);
    else if (pick == 2) text_bytes.push_back(ChMinus);
    pick = $urandom_range(0, 9);
    if (pick == 0)
      push_str(edge_numbers[$urandom_range(0, 3)]);
    else if (pick == 1)
      repeat ($urandom_range(8, 14)) text_bytes.push_back(ChZero + ByteW'($urandom_range(0, 9)));
    else if (pick != 2)
      repeat ($urandom_range(1, 4)) text_bytes.push_back(ChZero + ByteW'($urandom_range(0, 9)));
    if ($urandom_range(0, 9) == 0) text_bytes.push_back(ByteW'($urandom_range(33, 126)));
  endtask

  task automatic build_text();
    int rows;
    int cols;
    int keep;
    int pick;
    int r;
    int c;
    bit square;
    rows   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    square = $urandom_range(0, 99) < 65;
    add_run(row_delim, 0, 1);
    for (r = 0; r < rows; r++) begin
      add_run(col_delim, 0, 1);
      cols = square ? rows : $urandom_range(0, 6);
      for (c = 0; c < cols; c++) begin
        if (c > 0) add_run(col_delim, 1, 3);
        add_number();
      end
      add_run(col_delim, 0, 1);
      if (r < rows - 1) add_run(row_delim, 1, 2);
      else add_run(row_delim, 0, 1);
    end
    if (text_bytes.size() == 0) text_bytes.push_back(row_delim);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      keep = $urandom_range(1, text_bytes.size());
      while (text_bytes.size() > keep) void'(text_bytes.pop_back());
    end else if (pick < 27) begin
      text_bytes.delete();
      repeat ($urandom_range(1, 20)) text_bytes.push_back(ByteW'($urandom));
    end
  endtask

  task automatic choose_delimiters();
    logic [ByteW-1:0] x;
    x = ByteW'($urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: set_delimiters(RowDelimReset, ColDelimReset);
      3:       set_delimiters(8'd59, 8'd44);
      4:       set_delimiters(8'h00, 8'hFF);
      5:       set_delimiters(8'hFF, 8'h00);
      6:       set_delimiters(x, x);
      default: set_delimiters(ByteW'($urandom), ByteW'($urandom));
    endcase
  endtask

  task automatic test_field_conversion();
    push_str("-9999999999 +\n\t7 1a");
    send_text();
    text_bytes.push_back(RowDelimReset);
    send_text();
    settle();
  endtask

  task automatic test_equal_delimiters();
    set_delimiters(8'd59, 8'd59);
    push_str("4;;9");
    send_text();
    settle();
  endtask

  task automatic test_delimiter_extremes();
    set_delimiters(8'h00, 8'hFF);
    text_bytes = {8'd55, 8'hFF, 8'd56, 8'h00, 8'd57, 8'hFF, 8'd49, 8'h00};
    send_text();
    settle();
  endtask

  task automatic test_output_backpressure();
    @(posedge clk_i);
    rx_hold = HoldCycles;
    @(negedge clk_i);
    repeat (4) begin
      build_text();
      send_text();
    end
    settle();
  endtask

  task automatic test_random_texts();
    int start;
    int texts;
    start = items_sent;
    texts = 0;
    while (items_sent - start < RandomItems) begin
      if (texts % 6 == 5) begin
        settle();
        choose_delimiters();
      end
      quiet = (items_sent - start >= 500) && (items_sent - start < 800);
      build_text();
      send_text();
      texts++;
    end
    quiet = 1'b0;
    settle();
  endtask

  initial begin
    row_delim = RowDelimReset;
    col_delim = ColDelimReset;
    restart_parse();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_field_conversion();
    test_equal_delimiters();
    test_delimiter_extremes();
    test_output_backpressure();
    test_random_texts();

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mtpsq_pkg.sv
rtl/core/matrix_text_parser_square_check.sv
rtl/core/mtpsq_port_check.sv
tb/tb_matrix_text_parser_square_check.sv
